// ===== src/pidc_pkg.sv =====
`default_nettype none

package pidc_pkg;

  // default field format
  localparam int DATA_WIDTH_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // bits of the multiplier operand consumed per cycle
  localparam int DIGIT_BITS = 4;

  // configuration register map
  localparam int REG_COUNT = 8;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_KP  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KI  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KD  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TS  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IUP = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ILO = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_OUP = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_OLO = 3'd7;

  // item operation codes
  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // controller states: idle, one per product in flight, and the final clamp
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TS,
    ST_KP,
    ST_KI,
    ST_KD,
    ST_CLAMP
  } pidc_state_t;

endpackage

`default_nettype wire

// ===== src/pidc_if.sv =====
`default_nettype none

// input item channel
interface pidc_in_if #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic signed [DATA_WIDTH-1:0] measured;
  logic signed [DATA_WIDTH-1:0] target;

  modport source (output valid, operation, measured, target, input ready);
  modport sink   (input valid, operation, measured, target, output ready);
endinterface

// result item channel
interface pidc_out_if #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive;
  logic                         output_saturated;

  modport source (output valid, drive, output_saturated, input ready);
  modport sink   (input valid, drive, output_saturated, output ready);
endinterface

`default_nettype wire

// ===== src/pidc_regs.sv =====
`default_nettype none

module pidc_regs #(
  parameter int DATA_WIDTH    = pidc_pkg::DATA_WIDTH_DEF,
  parameter int FRACTION_BITS = pidc_pkg::FRACTION_BITS_DEF,
  parameter int PDATA_W       = 32,
  parameter int PADDR_W       = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [PADDR_W-1:0]           paddr,
  input  wire logic [PDATA_W-1:0]           pwdata,
  output logic      [PDATA_W-1:0]           prdata,
  output logic                              pready,
  output logic signed [DATA_WIDTH-1:0]      kp,
  output logic signed [DATA_WIDTH-1:0]      ki,
  output logic signed [DATA_WIDTH-1:0]      kd,
  output logic        [DATA_WIDTH-2:0]      ts,
  output logic signed [DATA_WIDTH-1:0]      iup,
  output logic signed [DATA_WIDTH-1:0]      ilo,
  output logic signed [DATA_WIDTH-1:0]      oup,
  output logic signed [DATA_WIDTH-1:0]      olo
);

  localparam int IDX_LSB = PADDR_W - pidc_pkg::REG_IDX_W;
  localparam logic [DATA_WIDTH-2:0] TS_ONE = (DATA_WIDTH-1)'(1) << FRACTION_BITS;

  logic                             wr;
  logic [pidc_pkg::REG_IDX_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[PADDR_W-1:IDX_LSB];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kp  <= '0;
      ki  <= '0;
      kd  <= '0;
      ts  <= TS_ONE;
      iup <= '0;
      ilo <= '0;
      oup <= '0;
      olo <= '0;
    end else if (wr) begin
      unique case (idx)
        pidc_pkg::REG_KP:  kp  <= pwdata[DATA_WIDTH-1:0];
        pidc_pkg::REG_KI:  ki  <= pwdata[DATA_WIDTH-1:0];
        pidc_pkg::REG_KD:  kd  <= pwdata[DATA_WIDTH-1:0];
        pidc_pkg::REG_TS:  ts  <= pwdata[DATA_WIDTH-2:0];
        pidc_pkg::REG_IUP: iup <= pwdata[DATA_WIDTH-1:0];
        pidc_pkg::REG_ILO: ilo <= pwdata[DATA_WIDTH-1:0];
        pidc_pkg::REG_OUP: oup <= pwdata[DATA_WIDTH-1:0];
        pidc_pkg::REG_OLO: olo <= pwdata[DATA_WIDTH-1:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      pidc_pkg::REG_KP:  prdata = PDATA_W'($unsigned(kp));
      pidc_pkg::REG_KI:  prdata = PDATA_W'($unsigned(ki));
      pidc_pkg::REG_KD:  prdata = PDATA_W'($unsigned(kd));
      pidc_pkg::REG_TS:  prdata = PDATA_W'(ts);
      pidc_pkg::REG_IUP: prdata = PDATA_W'($unsigned(iup));
      pidc_pkg::REG_ILO: prdata = PDATA_W'($unsigned(ilo));
      pidc_pkg::REG_OUP: prdata = PDATA_W'($unsigned(oup));
      pidc_pkg::REG_OLO: prdata = PDATA_W'($unsigned(olo));
    endcase
  end

endmodule

`default_nettype wire

// ===== src/pidc_mul.sv =====
`default_nettype none

// digit-serial signed multiplier: b is consumed one digit per cycle, lsb first,
// the partial sum shifts right and its low digits shift into lo
module pidc_mul #(
  parameter int DATA_WIDTH    = pidc_pkg::DATA_WIDTH_DEF,
  parameter int FRACTION_BITS = pidc_pkg::FRACTION_BITS_DEF,
  parameter int SUM_WIDTH     = 2 * DATA_WIDTH + 4 - FRACTION_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [DATA_WIDTH:0]    a,
  input  wire logic signed [DATA_WIDTH-1:0]  b,
  output logic                               done,
  output logic signed [SUM_WIDTH-1:0]        product
);

  localparam int DIG  = pidc_pkg::DIGIT_BITS;
  localparam int AW   = DATA_WIDTH + 1;
  localparam int NDIG = (DATA_WIDTH + DIG - 1) / DIG;
  localparam int BW   = NDIG * DIG;
  localparam int HW   = AW + DIG + 1;
  localparam int CW   = $clog2(NDIG);
  localparam int FW   = HW + BW;

  logic signed [AW-1:0]  a_reg;
  logic signed [BW-1:0]  b_sh;
  logic signed [HW-1:0]  acc;
  logic        [BW-1:0]  lo;
  logic        [CW-1:0]  cnt;
  logic                  busy;

  logic                  last;
  logic signed [DIG:0]   dig_s;
  logic signed [HW-1:0]  pp;
  logic signed [HW-1:0]  t;
  logic signed [FW-1:0]  full;
  logic signed [FW-1:0]  shifted;

  // one digit step: top digit carries the sign
  always_comb begin
    last    = (cnt == '0);
    dig_s   = last ? {b_sh[DIG-1], b_sh[DIG-1:0]} : {1'b0, b_sh[DIG-1:0]};
    pp      = a_reg * dig_s;
    t       = acc + pp;
    full    = $signed({acc, lo});
    shifted = full >>> FRACTION_BITS;
    product = shifted[SUM_WIDTH-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(NDIG - 1);
    end else if (busy) begin
      busy <= !last;
      done <= last;
      cnt  <= cnt - 1'b1;
    end else begin
      done <= 1'b0;
    end
  end

  // operand and partial sum shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_sh  <= BW'(b);
      acc   <= '0;
      lo    <= '0;
    end else if (busy) begin
      b_sh  <= b_sh >>> DIG;
      acc   <= t >>> DIG;
      lo    <= {t[DIG-1:0], lo[BW-1:DIG]};
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier started while busy");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (busy && last && !start) |=> done)
    else $error("multiplier finished without done");
  a_done_free: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while still busy");
`endif

endmodule

`default_nettype wire

// ===== src/pid_controller_clamped_integral.sv =====
`default_nettype none

// channel  | dir | fields
// req      | in  | operation, measured, target
// rsp      | out | drive, output_saturated
// apb      | in  | register writes and reads, pready always high
//
// a clear item zeroes the integral and previous error and yields no result;
// a compute item runs four products in turn (error*Ts, Kp, Ki, Kd) on the
// shared digit-serial multiplier, 4 bits per cycle, then the output clamp
// rst is synchronous; it clears the integral, previous error and registers
// (Ts resets to one); a finished result waits in the output register; a new
// item is taken meanwhile
module pid_controller_clamped_integral #(
  parameter int DATA_WIDTH    = pidc_pkg::DATA_WIDTH_DEF,
  parameter int FRACTION_BITS = pidc_pkg::FRACTION_BITS_DEF,
  parameter int PDATA_W       = (DATA_WIDTH > 32) ? 64 : 32,
  parameter int PADDR_W       = pidc_pkg::REG_IDX_W + ((DATA_WIDTH > 32) ? 3 : 2)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  pidc_in_if.sink                  req,
  pidc_out_if.source               rsp,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic      [PDATA_W-1:0]  prdata,
  output logic                     pready
);

  localparam int W     = DATA_WIDTH;
  localparam int AW    = W + 1;
  localparam int SUM_W = 2 * W + 4 - FRACTION_BITS;

  localparam logic signed [W-1:0]     DATA_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]     DATA_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX  = SUM_W'(DATA_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN  = SUM_W'(DATA_MIN);

  logic signed [W-1:0] kp, ki, kd, iup, ilo, oup, olo;
  logic        [W-2:0] ts;

  pidc_regs #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .PDATA_W       (PDATA_W),
    .PADDR_W       (PADDR_W)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .kp      (kp),
    .ki      (ki),
    .kd      (kd),
    .ts      (ts),
    .iup     (iup),
    .ilo     (ilo),
    .oup     (oup),
    .olo     (olo)
  );

  pidc_pkg::pidc_state_t state, state_next;

  logic signed [W-1:0]     integral;
  logic signed [W-1:0]     prev_err;
  logic signed [W-1:0]     err;
  logic signed [SUM_W-1:0] sum_acc;
  logic                    out_valid;
  logic signed [W-1:0]     out_drive;
  logic                    out_sat;

  logic                    accept_in;
  logic                    is_clear;
  logic signed [AW-1:0]    err_wide;
  logic signed [W-1:0]     err_in;
  logic                    mul_start;
  logic signed [AW-1:0]    mul_a;
  logic signed [W-1:0]     mul_b;
  logic                    mul_done;
  logic signed [SUM_W-1:0] mul_p;
  logic                    out_free;
  logic                    out_load;
  logic signed [SUM_W-1:0] int_wide;
  logic signed [W-1:0]     int_sat;
  logic signed [W-1:0]     int_next;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [W-1:0]     drive_c;
  logic                    sat_c;

  pidc_mul #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .SUM_WIDTH     (SUM_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  // saturated error of the incoming item
  always_comb begin
    err_wide = AW'(req.target) - AW'(req.measured);
    if (err_wide[W] != err_wide[W-1]) begin
      err_in = err_wide[W] ? DATA_MIN : DATA_MAX;
    end else begin
      err_in = err_wide[W-1:0];
    end
  end

  assign accept_in = req.valid & req.ready;
  assign is_clear  = (req.operation == pidc_pkg::OP_CLEAR);
  assign out_free  = !out_valid || rsp.ready;

  // integral update: saturate, then clamp with the upper bound tested first
  always_comb begin
    int_wide = SUM_W'(integral) + mul_p;
    if (int_wide > SUM_MAX) begin
      int_sat = DATA_MAX;
    end else if (int_wide < SUM_MIN) begin
      int_sat = DATA_MIN;
    end else begin
      int_sat = int_wide[W-1:0];
    end
    if (int_sat > iup) begin
      int_next = iup;
    end else if (int_sat < ilo) begin
      int_next = ilo;
    end else begin
      int_next = int_sat;
    end
  end

  // term sum and output clamp
  always_comb begin
    sum_next = sum_acc + mul_p;
    if (sum_acc > SUM_W'(oup)) begin
      drive_c = oup;
      sat_c   = 1'b1;
    end else if (sum_acc < SUM_W'(olo)) begin
      drive_c = olo;
      sat_c   = 1'b1;
    end else begin
      drive_c = sum_acc[W-1:0];
      sat_c   = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pidc_pkg::ST_IDLE:  if (accept_in && !is_clear) state_next = pidc_pkg::ST_TS;
      pidc_pkg::ST_TS:    if (mul_done) state_next = pidc_pkg::ST_KP;
      pidc_pkg::ST_KP:    if (mul_done) state_next = pidc_pkg::ST_KI;
      pidc_pkg::ST_KI:    if (mul_done) state_next = pidc_pkg::ST_KD;
      pidc_pkg::ST_KD:    if (mul_done) state_next = pidc_pkg::ST_CLAMP;
      pidc_pkg::ST_CLAMP: if (out_free) state_next = pidc_pkg::ST_IDLE;
    endcase
  end

  // controller outputs and multiplier operand select
  always_comb begin
    req.ready = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    out_load  = 1'b0;
    unique case (state)
      pidc_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        mul_start = req.valid && !is_clear;
        mul_a     = AW'(err_in);
        mul_b     = {1'b0, ts};
      end
      pidc_pkg::ST_TS: begin
        mul_start = mul_done;
        mul_a     = AW'(err);
        mul_b     = kp;
      end
      pidc_pkg::ST_KP: begin
        mul_start = mul_done;
        mul_a     = AW'(integral);
        mul_b     = ki;
      end
      pidc_pkg::ST_KI: begin
        mul_start = mul_done;
        mul_a     = AW'(err) - AW'(prev_err);
        mul_b     = kd;
      end
      pidc_pkg::ST_KD: begin
        mul_start = 1'b0;
      end
      pidc_pkg::ST_CLAMP: begin
        out_load = out_free;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pidc_pkg::ST_IDLE;
      integral  <= '0;
      prev_err  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept_in && is_clear) begin
        integral <= '0;
        prev_err <= '0;
      end
      if (state == pidc_pkg::ST_TS && mul_done) begin
        integral <= int_next;
      end
      if (out_load) begin
        prev_err  <= err;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept_in && !is_clear) begin
      err <= err_in;
    end
    if (mul_done) begin
      if (state == pidc_pkg::ST_KP) begin
        sum_acc <= mul_p;
      end else if (state == pidc_pkg::ST_KI || state == pidc_pkg::ST_KD) begin
        sum_acc <= sum_next;
      end
    end
    if (out_load) begin
      out_drive <= drive_c;
      out_sat   <= sat_c;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.drive            = out_drive;
  assign rsp.output_saturated = out_sat;

`ifndef SYNTHESIS
  a_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == pidc_pkg::ST_TS || state == pidc_pkg::ST_KP ||
                  state == pidc_pkg::ST_KI || state == pidc_pkg::ST_KD))
    else $error("product finished outside a multiply state");
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (accept_in && is_clear) |=> (integral == '0 && prev_err == '0))
    else $error("clear item left integral or previous error");
  a_int_clamped: assert property (@(posedge clk) disable iff (rst)
    (state == pidc_pkg::ST_TS && mul_done) |=> (integral <= iup || integral == ilo))
    else $error("integral outside its clamp");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> rsp.valid)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import pidc_pkg::*;

  localparam int DW          = 32;
  localparam int FRAC        = 16;
  localparam int PADDR_W     = REG_IDX_W + 2;
  localparam int STALL_LIMIT = 3000;
  localparam int IDLE_TAIL   = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 60;
  localparam int RAND_PHASES = 5;
  localparam int RAND_ITEMS  = 110;

  localparam logic signed [DW-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DW-1:0] Q_ONE    = 32'sh0001_0000;
  localparam longint LONG_MAX32 = 64'sd2147483647;
  localparam longint LONG_MIN32 = -64'sd2147483648;

  typedef struct packed {
    logic                 op;
    logic signed [DW-1:0] measured;
    logic signed [DW-1:0] target;
  } step_item_t;

  typedef struct packed {
    logic signed [DW-1:0] drive;
    logic                 sat;
  } drive_result_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN,
    RX_SPARSE
  } rx_mode_t;

  logic clk;
  logic rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  pidc_in_if  #(.DATA_WIDTH(DW)) req_if ();
  pidc_out_if #(.DATA_WIDTH(DW)) rsp_if ();

  pid_controller_clamped_integral #(
    .DATA_WIDTH    (DW),
    .FRACTION_BITS (FRAC)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow copy of the controller registers and state
  logic signed [DW-1:0] kp_set, ki_set, kd_set;
  logic        [DW-2:0] ts_set;
  logic signed [DW-1:0] int_hi_set, int_lo_set, out_hi_set, out_lo_set;
  longint               integ_acc;
  longint               last_error;

  step_item_t    step_queue[$];
  drive_result_t drive_expect[$];

  int unsigned queued_count;
  int unsigned accepted_count;
  int unsigned clear_count;
  int unsigned result_count;
  int unsigned clamped_count;
  int unsigned mismatch_count;
  int unsigned setting_count;

  // pacing knobs set per phase
  int unsigned max_gap;
  rx_mode_t    rx_mode;

  function automatic longint clip_word(input longint x);
    if (x > LONG_MAX32) return LONG_MAX32;
    if (x < LONG_MIN32) return LONG_MIN32;
    return x;
  endfunction

  // exact product, then floor shift back to Q16.16
  function automatic longint q_mul(input longint a, input longint b);
    return (a * b) >>> FRAC;
  endfunction

  // one control step on the shadow state; returns 1 when a result is due
  function automatic bit compute_drive(input logic op, input logic signed [DW-1:0] meas,
                                       input logic signed [DW-1:0] tgt,
                                       output drive_result_t res);
    longint err;
    longint acc;
    longint diff;
    longint total;
    res = '0;
    if (op == OP_CLEAR) begin
      integ_acc  = 0;
      last_error = 0;
      return 1'b0;
    end
    err = clip_word(longint'(tgt) - longint'(meas));
    acc = clip_word(integ_acc + q_mul(err, longint'(ts_set)));
    // upper bound wins when the limits are crossed
    if (acc > longint'(int_hi_set)) acc = longint'(int_hi_set);
    else if (acc < longint'(int_lo_set)) acc = longint'(int_lo_set);
    integ_acc = acc;
    diff  = err - last_error;
    total = q_mul(longint'(kp_set), err) + q_mul(longint'(ki_set), acc) +
            q_mul(longint'(kd_set), diff);
    if (total > longint'(out_hi_set)) begin
      total   = longint'(out_hi_set);
      res.sat = 1'b1;
    end else if (total < longint'(out_lo_set)) begin
      total   = longint'(out_lo_set);
      res.sat = 1'b1;
    end
    last_error = err;
    res.drive  = total[DW-1:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // item driver: bursts of random length, random gaps in between
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin : item_driver
    drive_result_t res;
    step_item_t    nxt;
    if (rst) begin
      req_if.valid <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        accepted_count++;
        if (req_if.operation == OP_CLEAR) clear_count++;
        if (compute_drive(req_if.operation, req_if.measured, req_if.target, res))
          drive_expect.push_back(res);
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (step_queue.size() != 0) begin
          nxt = step_queue.pop_front();
          req_if.valid     <= 1'b1;
          req_if.operation <= nxt.op;
          req_if.measured  <= nxt.measured;
          req_if.target    <= nxt.target;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
          end else begin
            burst_left--;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern, with one long hold-off
  int unsigned hold_left;
  bit          hold_done;
  int unsigned rx_tick;

  always @(posedge clk) begin : result_monitor
    drive_result_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      rx_tick   = 0;
    end else begin
      rx_tick++;
      if (rsp_if.valid && rsp_if.ready) begin
        result_count++;
        if (rsp_if.output_saturated) clamped_count++;
        if (drive_expect.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, drive %0d",
                                    rsp_if.drive));
        end else begin
          want = drive_expect.pop_front();
          if (rsp_if.drive !== want.drive)
            report_mismatch($sformatf("drive %0d, expected %0d", rsp_if.drive, want.drive));
          if (rsp_if.output_saturated !== want.sat)
            report_mismatch($sformatf("saturated flag %0b, expected %0b",
                                      rsp_if.output_saturated, want.sat));
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!hold_done && result_count >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  rsp_if.ready <= 1'b1;
          RX_RANDOM:  rsp_if.ready <= 1'($urandom_range(0, 1));
          RX_PATTERN: rsp_if.ready <= (rx_tick % 7) < 4;
          default:    rsp_if.ready <= ($urandom_range(0, 9) < 2);
        endcase
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // register write over the config port, shadow updated alongside
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_KP:  kp_set     = value;
      REG_KI:  ki_set     = value;
      REG_KD:  kd_set     = value;
      REG_TS:  ts_set     = value[DW-2:0];
      REG_IUP: int_hi_set = value;
      REG_ILO: int_lo_set = value;
      REG_OUP: out_hi_set = value;
      default: out_lo_set = value;
    endcase
  endtask

  task automatic load_settings(input logic signed [DW-1:0] kp, ki, kd,
                               input logic [DW-2:0] ts,
                               input logic signed [DW-1:0] ihi, ilo, ohi, olo);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_TS, {1'b0, ts});
    write_reg(REG_IUP, ihi);
    write_reg(REG_ILO, ilo);
    write_reg(REG_OUP, ohi);
    write_reg(REG_OLO, olo);
    setting_count++;
  endtask

  task automatic add_compute(input logic signed [DW-1:0] tgt, input logic signed [DW-1:0] meas);
    step_item_t it;
    it.op       = OP_COMPUTE;
    it.measured = meas;
    it.target   = tgt;
    step_queue.push_back(it);
    queued_count++;
  endtask

  // clear carries junk in the ignored fields
  task automatic add_clear();
    step_item_t it;
    it.op       = OP_CLEAR;
    it.measured = $urandom;
    it.target   = $urandom;
    step_queue.push_back(it);
    queued_count++;
  endtask

  // block idle: everything accepted, every result in, then the latency tail
  task automatic wait_idle();
    while (accepted_count != queued_count || drive_expect.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
      4, 5, 6:    return $urandom;
      7: begin
        case ($urandom_range(0, 3))
          0:       return WORD_MAX;
          1:       return WORD_MIN;
          2:       return 32'sh0;
          default: return -32'sh1;
        endcase
      end
      default: return $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
    endcase
  endfunction

  function automatic logic signed [DW-1:0] rand_gain();
    case ($urandom_range(0, 9))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return $urandom;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic logic signed [DW-1:0] rand_limit();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      default: return $signed($urandom_range(0, 32'h07d0_0000)) - 32'sh03e8_0000;
    endcase
  endfunction

  function automatic logic [DW-2:0] rand_period();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 31'h7fff_ffff;
      2:       return raw[DW-2:0];
      default: return (DW-1)'($urandom_range(1, 32'h0001_0000));
    endcase
  endfunction

  // sorted pair, now and then crossed on purpose
  task automatic rand_bounds(output logic signed [DW-1:0] hi, output logic signed [DW-1:0] lo);
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    a = rand_limit();
    b = rand_limit();
    if ((a >= b) ^ ($urandom_range(0, 6) == 0)) begin
      hi = a;
      lo = b;
    end else begin
      hi = b;
      lo = a;
    end
  endtask

  initial begin : stimulus
    logic signed [DW-1:0] ihi, ilo, ohi, olo, tgt;
    rst              = 1'b1;
    req_if.valid     = 1'b0;
    req_if.operation = OP_COMPUTE;
    req_if.measured  = '0;
    req_if.target    = '0;
    rsp_if.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    kp_set = '0; ki_set = '0; kd_set = '0;
    ts_set = 31'h0001_0000;
    int_hi_set = '0; int_lo_set = '0; out_hi_set = '0; out_lo_set = '0;
    integ_acc = 0; last_error = 0;
    queued_count = 0; accepted_count = 0; clear_count = 0;
    result_count = 0; clamped_count = 0; mismatch_count = 0; setting_count = 0;
    max_gap = 3;
    rx_mode = RX_RANDOM;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // settings out of reset: all limits zero
    add_compute(Q_ONE, 32'sh0);
    add_compute(-Q_ONE, Q_ONE);
    wait_idle();

    // moderate gains, error overflow both ways, clear with junk fields
    max_gap = 0;
    rx_mode = RX_ALWAYS;
    load_settings(Q_ONE, 32'sh0000_8000, 32'sh0000_4000, 31'd655,
                  32'sh0064_0000, -32'sh0064_0000, 32'sh0032_0000, -32'sh0032_0000);
    add_compute(Q_ONE, 32'sh0);
    add_compute(WORD_MAX, WORD_MIN);
    add_compute(WORD_MIN, WORD_MAX);
    add_compute(32'sh0, 32'sh0);
    add_clear();
    add_compute(WORD_MAX, -32'sh1);
    add_compute(32'sh0, WORD_MIN);
    add_clear();
    add_compute(-Q_ONE, Q_ONE);
    wait_idle();

    // extreme gains and period: integral sum overflows both ways
    max_gap = 5;
    rx_mode = RX_PATTERN;
    load_settings(WORD_MAX, WORD_MIN, WORD_MAX, 31'h7fff_ffff,
                  WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
    add_compute(WORD_MAX, WORD_MIN);
    add_compute(WORD_MAX, WORD_MIN);
    add_compute(WORD_MIN, WORD_MAX);
    add_compute(WORD_MIN, WORD_MAX);
    add_compute(32'sh0, 32'sh0);
    wait_idle();

    // crossed limits and zero period
    rx_mode = RX_SPARSE;
    load_settings(Q_ONE, Q_ONE, WORD_MIN, 31'd0,
                  -32'sh000a_0000, 32'sh000a_0000, -32'sh0005_0000, 32'sh0005_0000);
    add_compute(32'sh0014_0000, 32'sh0);
    add_compute(-32'sh0014_0000, 32'sh0);
    add_clear();
    add_compute(32'sh0, 32'sh0);
    add_compute(WORD_MIN, WORD_MIN);
    wait_idle();

    // random settings, mostly tracking steps around a setpoint
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      max_gap = (ph == 1) ? 0 : $urandom_range(1, 10);
      rx_mode = (ph == 1) ? RX_ALWAYS : rx_mode_t'($urandom_range(1, 3));
      rand_bounds(ihi, ilo);
      rand_bounds(ohi, olo);
      load_settings(rand_gain(), rand_gain(), rand_gain(), rand_period(), ihi, ilo, ohi, olo);
      tgt = rand_value();
      for (int n = 0; n < RAND_ITEMS; n++) begin
        case ($urandom_range(0, 19))
          0, 1: add_clear();
          2:    tgt = rand_value();
          3, 4, 5, 6: add_compute(rand_value(), rand_value());
          default: add_compute(tgt, tgt + $signed($urandom_range(0, 32'h0003_ffff))
                                        - 32'sh0002_0000);
        endcase
      end
      wait_idle();
    end

    $display("ran %0d items (%0d clears) over %0d register settings",
             accepted_count, clear_count, setting_count);
    $display("checked %0d results, %0d of them clamped, %0d mismatches",
             result_count, clamped_count, mismatch_count);
    if (mismatch_count == 0 && drive_expect.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
